### design/cfia_pkg.sv
// ----------------------------------------------------------------------------
// Constant-fold integer ALU package
// Opcodes, operand types, pipeline payload types and small helpers.
// ----------------------------------------------------------------------------
package cfia_pkg;

  localparam int DIV_STAGES = 64;

  localparam logic [4:0] OP_ADD  = 5'd0;
  localparam logic [4:0] OP_SUB  = 5'd1;
  localparam logic [4:0] OP_AND  = 5'd2;
  localparam logic [4:0] OP_OR   = 5'd3;
  localparam logic [4:0] OP_XOR  = 5'd4;
  localparam logic [4:0] OP_SHL  = 5'd5;
  localparam logic [4:0] OP_SHR  = 5'd6;
  localparam logic [4:0] OP_SAR  = 5'd7;
  localparam logic [4:0] OP_ROR  = 5'd8;
  localparam logic [4:0] OP_MUL  = 5'd9;
  localparam logic [4:0] OP_UMULL = 5'd10;
  localparam logic [4:0] OP_SMULL = 5'd11;
  localparam logic [4:0] OP_UBFX = 5'd12;
  localparam logic [4:0] OP_DIV  = 5'd13;
  localparam logic [4:0] OP_UDIV = 5'd14;
  localparam logic [4:0] OP_SMOD = 5'd15;
  localparam logic [4:0] OP_UMOD = 5'd16;

  localparam logic [1:0] TY_I32 = 2'd0;
  localparam logic [1:0] TY_I64 = 2'd1;
  localparam logic [1:0] TY_F64 = 2'd2;
  localparam logic [1:0] TY_ALT = 2'd3;

  localparam logic [63:0] MOST_NEG_64 = 64'h8000_0000_0000_0000;
  localparam logic [31:0] MOST_NEG_32 = 32'h8000_0000;

  typedef struct packed {
    logic ok;
    logic wide;
    logic narrow;
    logic shl_ge32;
    logic dwide;
    logic is_div;
    logic sel_rem;
    logic neg_q;
    logic neg_r;
    logic is_mul;
  } ctl_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [63:0] res;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] dvs;
  } pipe_t;

  function automatic logic [63:0] sext32(input logic [63:0] v);
    sext32 = {{32{v[31]}}, v[31:0]};
  endfunction

endpackage

### design/cfia_div_step.sv
// ----------------------------------------------------------------------------
// Divider step
// One restoring bit of an unsigned 64-bit division.
// ----------------------------------------------------------------------------
module cfia_div_step (
  input  logic [63:0] rem_i,
  input  logic [63:0] quo_i,
  input  logic [63:0] dvs_i,
  output logic [63:0] rem_o,
  output logic [63:0] quo_o
);
  import cfia_pkg::*;

  logic [64:0] shifted;
  logic [65:0] diff;
  logic        ge;

  always_comb begin
    shifted = {rem_i, quo_i[63]};
    diff    = {1'b0, shifted} - {2'b00, dvs_i};
    ge      = ~diff[65];
    rem_o   = ge ? diff[63:0] : shifted[63:0];
    quo_o   = {quo_i[62:0], ge};
  end

endmodule

### design/const_fold_integer_alu_core.sv
// ----------------------------------------------------------------------------
// Constant-fold integer ALU core
// Throughput: one request per cycle unless the output register is full and
// out_tready is low; the 64 one-bit divider stages set the depth.
// The pipeline advances as one while the output register is empty or read.
// Reset (rst_n low, synchronous) clears every stage valid bit and out_tvalid.
// ----------------------------------------------------------------------------
module const_fold_integer_alu_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode[4:0], operand_a[68:5], operand_b[132:69], operand_type[134:133],
  // dest_is_wide[135]
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result[63:0], ok[64], result_is_wide[65], zero padding[71:66]
  output logic [71:0]  out_tdata
);
  import cfia_pkg::*;

  logic en;

  // Input register.
  logic        s0_vld_r;
  logic [4:0]  s0_op_r;
  logic [63:0] s0_a_r, s0_b_r;
  logic [1:0]  s0_ty_r;
  logic        s0_dw_r;

  // Decode / execute stage.
  logic        s1_vld_r;
  ctl_t        s1_ctl_r, s1_ctl_nxt;
  logic [63:0] s1_res_r, s1_res_nxt;
  logic [63:0] s1_da_r, s1_da_nxt, s1_db_r, s1_db_nxt;
  logic [63:0] s1_pll_r, s1_pll_nxt;
  logic [31:0] s1_plh_r, s1_plh_nxt, s1_phl_r, s1_phl_nxt;

  logic        stg_vld_r [0:DIV_STAGES];
  pipe_t       stg_r     [0:DIV_STAGES];
  pipe_t       s2_nxt;

  logic        out_vld_r;
  logic [71:0] out_data_r, out_data_nxt;

  assign en         = ~out_vld_r | out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_tvalid;
    end
    if (en) begin
      s0_op_r <= in_tdata[4:0];
      s0_a_r  <= in_tdata[68:5];
      s0_b_r  <= in_tdata[132:69];
      s0_ty_r <= in_tdata[134:133];
      s0_dw_r <= in_tdata[135];
    end
  end

  logic        is64, shr_zero;
  logic [5:0]  sh;
  logic [4:0]  ubfx_w;
  logic [63:0] ma, mb, sa, sb, rot2, ubfx_mask;

  always_comb begin
    is64      = (s0_ty_r == TY_I64);
    sh        = s0_b_r[5:0];
    shr_zero  = sh[5];
    ubfx_w    = s0_b_r[9:5];
    ubfx_mask = (64'd1 << ubfx_w) - 64'd1;
    rot2      = {s0_a_r[31:0], s0_a_r[31:0]} >> s0_b_r[4:0];
    s1_ctl_nxt          = '0;
    s1_ctl_nxt.ok       = 1'b1;
    s1_ctl_nxt.wide     = is64;
    s1_ctl_nxt.narrow   = (s0_ty_r == TY_I32) || (s0_ty_r == TY_ALT);
    s1_ctl_nxt.dwide    = s0_dw_r;
    s1_ctl_nxt.shl_ge32 = (s0_op_r == OP_SHL) && !s0_b_r[63] && (|s0_b_r[62:5]);
    s1_res_nxt = '0;
    ma = s0_a_r;
    mb = s0_b_r;
    sa = s0_a_r;
    sb = s0_b_r;
    s1_da_nxt = '0;
    s1_db_nxt = '0;
    case (s0_op_r)
      OP_ADD: s1_res_nxt = s0_a_r + s0_b_r;
      OP_SUB: s1_res_nxt = s0_a_r - s0_b_r;
      OP_AND: s1_res_nxt = s0_a_r & s0_b_r;
      OP_OR:  s1_res_nxt = s0_a_r | s0_b_r;
      OP_XOR: s1_res_nxt = s0_a_r ^ s0_b_r;
      OP_SHL: s1_res_nxt = s0_a_r << sh;
      OP_SHR: begin
        if (is64) begin
          s1_res_nxt = s0_a_r >> sh;
        end else begin
          s1_res_nxt = shr_zero ? 64'd0 : ({32'd0, s0_a_r[31:0]} >> sh);
        end
      end
      OP_SAR: s1_res_nxt = $signed(s0_a_r) >>> sh;
      OP_ROR: s1_res_nxt = sext32(rot2);
      OP_MUL: s1_ctl_nxt.is_mul = 1'b1;
      OP_UMULL: begin
        s1_ctl_nxt.is_mul = 1'b1;
        s1_ctl_nxt.wide   = 1'b1;
        ma = {32'd0, s0_a_r[31:0]};
        mb = {32'd0, s0_b_r[31:0]};
      end
      OP_SMULL: begin
        s1_ctl_nxt.is_mul = 1'b1;
        s1_ctl_nxt.wide   = 1'b1;
        ma = sext32(s0_a_r);
        mb = sext32(s0_b_r);
      end
      OP_UBFX: begin
        if (ubfx_w == 5'd0) begin
          s1_ctl_nxt.ok = 1'b0;
        end
        s1_res_nxt = ({32'd0, s0_a_r[31:0]} >> s0_b_r[4:0]) & ubfx_mask;
      end
      OP_DIV, OP_SMOD: begin
        s1_ctl_nxt.is_div  = 1'b1;
        s1_ctl_nxt.sel_rem = (s0_op_r == OP_SMOD);
        if (is64) begin
          if ((s0_b_r == 64'd0) || ((&s0_b_r) && (s0_a_r == MOST_NEG_64))) begin
            s1_ctl_nxt.ok = 1'b0;
          end
        end else begin
          sa = sext32(s0_a_r);
          sb = sext32(s0_b_r);
          if ((s0_b_r[31:0] == 32'd0) ||
              ((&s0_b_r[31:0]) && (s0_a_r[31:0] == MOST_NEG_32))) begin
            s1_ctl_nxt.ok = 1'b0;
          end
        end
        s1_ctl_nxt.neg_q = sa[63] ^ sb[63];
        s1_ctl_nxt.neg_r = sa[63];
        s1_da_nxt = sa[63] ? (~sa + 64'd1) : sa;
        s1_db_nxt = sb[63] ? (~sb + 64'd1) : sb;
      end
      OP_UDIV, OP_UMOD: begin
        s1_ctl_nxt.is_div  = 1'b1;
        s1_ctl_nxt.sel_rem = (s0_op_r == OP_UMOD);
        if (is64) begin
          s1_da_nxt = s0_a_r;
          s1_db_nxt = s0_b_r;
        end else begin
          s1_da_nxt = {32'd0, s0_a_r[31:0]};
          s1_db_nxt = {32'd0, s0_b_r[31:0]};
        end
        if (s1_db_nxt == 64'd0) begin
          s1_ctl_nxt.ok = 1'b0;
        end
      end
      default: s1_ctl_nxt.ok = 1'b0;
    endcase
    // Low 64 bits of the product only need the three lower partial products.
    s1_pll_nxt = {32'd0, ma[31:0]} * {32'd0, mb[31:0]};
    s1_plh_nxt = 32'(ma[31:0] * mb[63:32]);
    s1_phl_nxt = 32'(ma[63:32] * mb[31:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= s0_vld_r;
    end
    if (en) begin
      s1_ctl_r <= s1_ctl_nxt;
      s1_res_r <= s1_res_nxt;
      s1_da_r  <= s1_da_nxt;
      s1_db_r  <= s1_db_nxt;
      s1_pll_r <= s1_pll_nxt;
      s1_plh_r <= s1_plh_nxt;
      s1_phl_r <= s1_phl_nxt;
    end
  end

  always_comb begin
    s2_nxt.ctl = s1_ctl_r;
    s2_nxt.res = s1_ctl_r.is_mul ?
                 (s1_pll_r + {s1_plh_r + s1_phl_r, 32'd0}) : s1_res_r;
    s2_nxt.rem = '0;
    s2_nxt.quo = s1_da_r;
    s2_nxt.dvs = s1_db_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r[0] <= 1'b0;
    end else if (en) begin
      stg_vld_r[0] <= s1_vld_r;
    end
    if (en) begin
      stg_r[0] <= s2_nxt;
    end
  end

  genvar k;
  generate
    for (k = 0; k < DIV_STAGES; k++) begin : g_div
      logic [63:0] rem_nxt, quo_nxt;

      cfia_div_step u_step (
        .rem_i (stg_r[k].rem),
        .quo_i (stg_r[k].quo),
        .dvs_i (stg_r[k].dvs),
        .rem_o (rem_nxt),
        .quo_o (quo_nxt)
      );

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stg_vld_r[k+1] <= 1'b0;
        end else if (en) begin
          stg_vld_r[k+1] <= stg_vld_r[k];
        end
        if (en) begin
          stg_r[k+1].ctl <= stg_r[k].ctl;
          stg_r[k+1].res <= stg_r[k].res;
          stg_r[k+1].dvs <= stg_r[k].dvs;
          stg_r[k+1].rem <= rem_nxt;
          stg_r[k+1].quo <= quo_nxt;
        end
      end
    end
  endgenerate

  ctl_t        fc;
  logic [63:0] fv;
  logic        f_ok, f_wide;

  always_comb begin
    fc = stg_r[DIV_STAGES].ctl;
    if (fc.is_div) begin
      if (fc.sel_rem) begin
        fv = fc.neg_r ? (~stg_r[DIV_STAGES].rem + 64'd1) : stg_r[DIV_STAGES].rem;
      end else begin
        fv = fc.neg_q ? (~stg_r[DIV_STAGES].quo + 64'd1) : stg_r[DIV_STAGES].quo;
      end
    end else begin
      fv = stg_r[DIV_STAGES].res;
    end
    f_ok   = fc.ok;
    f_wide = fc.wide;
    if (f_ok && fc.narrow && !fc.wide) begin
      // A 32-bit SHL past the low word stays whole if dwide, else not ok.
      if (fc.shl_ge32) begin
        if (fc.dwide) begin
          f_wide = 1'b1;
        end else begin
          f_ok = 1'b0;
        end
      end else begin
        fv = sext32(fv);
      end
    end
    if (!f_ok) begin
      fv     = '0;
      f_wide = 1'b0;
    end
    out_data_nxt = {6'd0, f_wide, f_ok, fv};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= stg_vld_r[DIV_STAGES];
    end
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
